// ===== sv/wbvd_pkg.sv =====
// Package for the windowed band vote direction block.
// Holds widths, range table, band count types and the vote result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbvd_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int COUNT_BITS    = 16;
   localparam int WINDOW_BITS   = 16;
   localparam int NUM_BANDS     = 4;
   localparam int NUM_RANGES    = 6;
   localparam int BAND_IDX_BITS = $clog2(NUM_BANDS);
   localparam int DIR_BITS      = 3;
   localparam int RESULT_BITS   = 16;

   // Compare width is wide enough for both the sample and the largest bound.
   localparam int CMP_BITS = (SAMPLE_BITS > 11) ? SAMPLE_BITS : 11;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(25000);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [CMP_BITS-1:0]      lo;
      logic [CMP_BITS-1:0]      hi;
      logic [BAND_IDX_BITS-1:0] band;
   } range_type;

   // Open ranges, both bounds excluded; band index counts from zero.
   localparam range_type RANGES [NUM_RANGES] = '{
      '{lo: CMP_BITS'(908), hi: CMP_BITS'(980),  band: BAND_IDX_BITS'(0)},
      '{lo: CMP_BITS'(150), hi: CMP_BITS'(190),  band: BAND_IDX_BITS'(1)},
      '{lo: CMP_BITS'(750), hi: CMP_BITS'(780),  band: BAND_IDX_BITS'(2)},
      '{lo: CMP_BITS'(475), hi: CMP_BITS'(510),  band: BAND_IDX_BITS'(3)},
      '{lo: CMP_BITS'(645), hi: CMP_BITS'(700),  band: BAND_IDX_BITS'(2)},
      '{lo: CMP_BITS'(960), hi: CMP_BITS'(1020), band: BAND_IDX_BITS'(3)}
   };

   typedef logic [NUM_BANDS-1:0][COUNT_BITS-1:0] count_array_type;

   typedef struct packed {
      logic [DIR_BITS-1:0]   direction;
      logic [COUNT_BITS-1:0] count;
   } vote_type;

endpackage

`default_nettype wire

// ===== sv/wbvd_band_decode.sv =====
// Range decoder: maps one sample onto the set of bands it falls in.
// Depends on wbvd_pkg for the range table and widths.
`timescale 1ns / 1ps
`default_nettype none

module wbvd_band_decode
   import wbvd_pkg::*;
(
   input  wire logic [SAMPLE_BITS-1:0] sample,
   output logic      [NUM_BANDS-1:0]   band_hit
);

   logic [CMP_BITS-1:0] sample_wide;

   assign sample_wide = CMP_BITS'(sample);

   // A sample between 961 and 979 sets both band 0 and band 3.
   always_comb begin
      band_hit = '0;
      for (int r = 0; r < NUM_RANGES; r++) begin
         if (sample_wide > RANGES[r].lo && sample_wide < RANGES[r].hi) begin
            band_hit[RANGES[r].band] = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/wbvd_argmax.sv =====
// Picks the band with the highest count; the lowest band wins a tie.
// Depends on wbvd_pkg for the count array and vote result types.
`timescale 1ns / 1ps
`default_nettype none

module wbvd_argmax
   import wbvd_pkg::*;
(
   input  wire count_array_type counts,
   output vote_type             vote
);

   logic [BAND_IDX_BITS-1:0] best;
   logic [COUNT_BITS-1:0]    best_count;

   // Strict compare keeps the earlier band on a tie.
   always_comb begin
      best       = '0;
      best_count = counts[0];
      for (int b = 1; b < NUM_BANDS; b++) begin
         if (counts[b] > best_count) begin
            best       = BAND_IDX_BITS'(b);
            best_count = counts[b];
         end
      end
   end

   assign vote.direction = DIR_BITS'(best) + DIR_BITS'(1);
   assign vote.count     = best_count;

endmodule

`default_nettype wire

// ===== sv/windowed_band_vote_direction_top.sv =====
// Windowed band vote direction, top level.
// Results: a window-closing sample passes the input register, and its vote is then held
// in the result register, which drives rsp_valid and the outputs until the result is taken.
// Throughput: one sample per cycle, with the counters updated per sample; the input
// stalls only while a window-closing sample waits behind a result that is not yet taken.
// Reset (synchronous, active high) clears all band counters and the sample count,
// empties both pipeline registers and sets the window length to 25000.
`timescale 1ns / 1ps
`default_nettype none

module windowed_band_vote_direction_top
   import wbvd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [DIR_BITS-1:0]    rsp_direction,
   output logic      [RESULT_BITS-1:0] rsp_winning_count,

   input  wire logic                   csr_wr_en,
   input  wire logic [WINDOW_BITS-1:0] csr_wr_data
);

   // Window length. Software must write it only while idle; the block does not enforce it.
   logic [WINDOW_BITS-1:0] window_length_ff;
   logic [WINDOW_BITS-1:0] limit;

   // Input register: the accepted sample waits here while it is processed.
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;

   // Window state: the sample count and the band counters.
   logic [WINDOW_BITS-1:0] samples_seen_ff, samples_seen_in;
   count_array_type        counts_ff, counts_in;

   // Result register that parts the processing stage from the consumer.
   logic                   rsp_valid_ff, rsp_valid_in;
   vote_type               rsp_vote_ff, rsp_vote_in;

   logic [NUM_BANDS-1:0]   band_hit;
   count_array_type        counts_bumped;
   vote_type               vote;
   logic [WINDOW_BITS-1:0] seen_next;
   logic                   window_close;
   logic                   advance;

   wbvd_band_decode u_decode (
      .sample   (in_sample_ff),
      .band_hit (band_hit)
   );

   // Each band bumps at most once per sample and saturates at its maximum.
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         if (band_hit[b] && counts_ff[b] != COUNT_MAX) begin
            counts_bumped[b] = counts_ff[b] + COUNT_BITS'(1);
         end else begin
            counts_bumped[b] = counts_ff[b];
         end
      end
   end

   // The vote looks at the counts including the sample that closes the window.
   wbvd_argmax u_argmax (
      .counts (counts_bumped),
      .vote   (vote)
   );

   // A zero window length behaves as one. A window shortened below the current
   // count closes on the next sample, and a wrapped count closes the window too.
   assign limit        = (window_length_ff == '0) ? WINDOW_BITS'(1) : window_length_ff;
   assign seen_next    = samples_seen_ff + WINDOW_BITS'(1);
   assign window_close = (seen_next == '0) || (seen_next >= limit);

   // The staged sample moves on unless it closes a window while the result
   // register still holds a result that is not taken in this cycle.
   assign advance   = in_valid_ff && !(window_close && rsp_valid_ff && !rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
         in_sample_in = req_sample;
      end
   end

   always_comb begin
      samples_seen_in = samples_seen_ff;
      counts_in       = counts_ff;
      if (advance) begin
         if (window_close) begin
            samples_seen_in = '0;
            counts_in       = '0;
         end else begin
            samples_seen_in = seen_next;
            counts_in       = counts_bumped;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vote_in  = rsp_vote_ff;
      if (advance && window_close) begin
         rsp_valid_in = 1'b1;
         rsp_vote_in  = vote;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
         in_valid_ff      <= 1'b0;
         samples_seen_ff  <= '0;
         counts_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_length_ff <= csr_wr_data;
         end
         in_valid_ff     <= in_valid_in;
         samples_seen_ff <= samples_seen_in;
         counts_ff       <= counts_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
      rsp_vote_ff  <= rsp_vote_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_direction     = rsp_vote_ff.direction;
   assign rsp_winning_count = RESULT_BITS'(rsp_vote_ff.count);

`ifndef SYNTH
   // A presented result always names one of the four bands.
   a_direction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_direction != '0 && rsp_direction <= DIR_BITS'(NUM_BANDS)))
      else $error("result direction outside bands 1 to 4");

   // Input backpressure only arises from a staged sample and a held result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   // Closing a window clears the window state and presents a result.
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && window_close) |=> (samples_seen_ff == '0 && counts_ff == '0 && rsp_valid))
      else $error("window close did not clear counters or present a result");

   // A processed sample that keeps the window open advances the sample count.
   a_seen_step: assert property (@(posedge clock) disable iff (reset)
      (advance && !window_close) |=> (samples_seen_ff == $past(seen_next)))
      else $error("sample count did not advance");
`endif

endmodule

`default_nettype wire
